// ----- design/scfla_pkg.sv -----
// Shared types, codes and size-class helpers for the size-class allocator.
// No dependencies; imported by size_class_free_list_allocator.
`default_nettype none

package scfla_pkg;

    localparam int SMALL_CLASSES     = 256;
    localparam int LARGE_CLASSES     = 64;
    localparam int NUM_CLASSES       = SMALL_CLASSES + LARGE_CLASSES + 2;
    localparam int REGION_GRANULES   = 65536;
    localparam int SMALL_LIMIT_BYTES = SMALL_CLASSES * 16;

    localparam int CLASS_W = 9;
    localparam int GRAN_W  = 16;
    localparam int TOP_W   = 17;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_SPACE   = 3'd1;
    localparam logic [2:0] STAT_LARGE   = 3'd2;
    localparam logic [2:0] STAT_NOTLIVE = 3'd3;
    localparam logic [2:0] STAT_CORRUPT = 3'd4;

    // per-granule block status
    localparam logic [1:0] BS_NONE  = 2'd0;
    localparam logic [1:0] BS_LIVE  = 2'd1;
    localparam logic [1:0] BS_FREED = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] request_bytes;
        logic        has_block;
        logic [15:0] block_granule;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        result_valid;
        logic [15:0] result_granule;
        logic [18:0] copy_bytes;
        logic [16:0] used_granules;
    } rsp_t;

    typedef struct packed {
        logic               too_large;
        logic [CLASS_W-1:0] cls;
    } cls_info_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_A_HEAD,
        S_A_POP,
        S_F_CHK,
        S_R_CHK,
        S_P_WR,
        S_FINISH
    } state_t;

    // size in bytes -> class; zero counts as one byte
    function automatic cls_info_t class_of(input logic [23:0] bytes);
        logic [23:0] b;
        logic [24:0] sum;
        logic [12:0] pages;
        cls_info_t   info;
        b = (bytes == 24'd0) ? 24'd1 : bytes;
        info.too_large = 1'b0;
        info.cls       = '0;
        sum            = '0;
        pages          = '0;
        if (b <= 24'(SMALL_LIMIT_BYTES))
        begin
            sum      = {1'b0, b} + 25'd15;
            info.cls = sum[12:4];
        end
        else
        begin
            sum   = {1'b0, b} + 25'd4095;
            pages = sum[24:12];
            if (pages > 13'(LARGE_CLASSES))
                info.too_large = 1'b1;
            else
                info.cls = 9'(SMALL_CLASSES) + pages[8:0];
        end
        return info;
    endfunction

    // capacity of a class in granules (pages are 256 granules)
    function automatic logic [15:0] cap_granules(input logic [CLASS_W-1:0] cls);
        logic [CLASS_W-1:0] diff;
        diff = cls - 9'(SMALL_CLASSES);
        if (cls <= 9'(SMALL_CLASSES))
            return {7'd0, cls};
        else
            return {diff[7:0], 8'd0};
    endfunction

endpackage

`default_nettype wire

// ----- design/size_class_free_list_allocator.sv -----
// Size-class free-list allocator with bump pointer: top level. Depends on scfla_pkg.
// A request runs from decode through the states its kind needs (list-head check, pop,
// free or reallocate check, push) to finish; an early reject or no-op goes straight
// to finish. One request in flight; the block returns to idle, ready for the next,
// as the response registers; a finished request waits while the previous one is unaccepted.
// Reset: asynchronous, active low, then a pass over every granule clears status and list heads.
`default_nettype none

module size_class_free_list_allocator (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire scfla_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output scfla_pkg::rsp_t      rsp,
    input  wire logic            cfg_write,
    input  wire logic [16:0]     cfg_data
);
    import scfla_pkg::*;

    // ------------------------------------------------------------------
    // On-chip stores. Heads: one per class, 0 = empty list. Status, class
    // and link are indexed by payload granule; class and link are only
    // read for blocks whose status says they were written.
    // ------------------------------------------------------------------
    logic [GRAN_W-1:0]  heads_mem [0:NUM_CLASSES-1];
    logic [1:0]         stat_mem  [0:REGION_GRANULES-1];
    logic [CLASS_W-1:0] class_mem [0:REGION_GRANULES-1];
    logic [GRAN_W-1:0]  link_mem  [0:REGION_GRANULES-1];

    logic [GRAN_W-1:0]  heads_rd_reg;
    logic [1:0]         stat_rd_reg;
    logic [CLASS_W-1:0] class_rd_reg;
    logic [GRAN_W-1:0]  link_rd_reg;

    // memory port controls from the sequencer
    logic [CLASS_W-1:0] heads_raddr;
    logic               heads_we;
    logic [CLASS_W-1:0] heads_waddr;
    logic [GRAN_W-1:0]  heads_wdata;
    logic [GRAN_W-1:0]  meta_raddr;
    logic [GRAN_W-1:0]  meta_waddr;
    logic               stat_we;
    logic [1:0]         stat_wdata;
    logic               class_we;
    logic               link_we;
    logic [GRAN_W-1:0]  link_wdata;

    // control state
    state_t             state_reg, state_next;
    logic [GRAN_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [TOP_W-1:0]   bump_reg, bump_next;
    logic [TOP_W-1:0]   limit_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    // captured request and working values
    logic [1:0]         op_reg, op_next;
    logic [23:0]        bytes_reg, bytes_next;
    logic               has_reg, has_next;
    logic [GRAN_W-1:0]  g_reg, g_next;
    logic [CLASS_W-1:0] cls_reg, cls_next;
    logic               big_reg, big_next;
    logic               move_reg, move_next;
    logic [CLASS_W-1:0] old_cls_reg, old_cls_next;
    logic [19:0]        old_bytes_reg, old_bytes_next;
    logic [2:0]         st_reg, st_next;
    logic               ok_reg, ok_next;
    logic [GRAN_W-1:0]  where_reg, where_next;
    logic [18:0]        copy_reg, copy_next;

    // datapath helpers
    cls_info_t          req_info;
    logic [TOP_W-1:0]   limit_eff;
    logic [TOP_W:0]     end_top;
    logic [19:0]        rd_old_bytes;
    logic               alloc_path;
    logic               free_path;

    assign req_info     = class_of(req.request_bytes);
    // effective limit is min(reserve_limit, region)
    assign limit_eff    = (limit_reg > 17'(REGION_GRANULES)) ? 17'(REGION_GRANULES)
                                                              : limit_reg;
    // bump end: header granule plus class capacity
    assign end_top      = {1'b0, bump_reg} + 18'd1 + {2'b00, cap_granules(cls_reg)};
    assign rd_old_bytes = {cap_granules(class_rd_reg), 4'd0};
    assign alloc_path   = (op_reg == OP_ALLOC) || ((op_reg == OP_REALLOC) && !has_reg);
    assign free_path    = (op_reg == OP_FREE) ||
                          ((op_reg == OP_REALLOC) && (bytes_reg == 24'd0));

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Memories: one write and one registered read per store per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (heads_we)
            heads_mem[heads_waddr] <= heads_wdata;
        heads_rd_reg <= heads_mem[heads_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
            stat_mem[meta_waddr] <= stat_wdata;
        stat_rd_reg <= stat_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (class_we)
            class_mem[meta_waddr] <= cls_reg;
        class_rd_reg <= class_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[meta_waddr] <= link_wdata;
        link_rd_reg <= link_mem[meta_raddr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            bump_reg      <= 17'd1;
            limit_reg     <= 17'(REGION_GRANULES);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            bump_reg      <= bump_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_write)
                limit_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        op_reg        <= op_next;
        bytes_reg     <= bytes_next;
        has_reg       <= has_next;
        g_reg         <= g_next;
        cls_reg       <= cls_next;
        big_reg       <= big_next;
        move_reg      <= move_next;
        old_cls_reg   <= old_cls_next;
        old_bytes_reg <= old_bytes_next;
        st_reg        <= st_next;
        ok_reg        <= ok_next;
        where_reg     <= where_next;
        copy_reg      <= copy_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        bump_next      = bump_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        op_next        = op_reg;
        bytes_next     = bytes_reg;
        has_next       = has_reg;
        g_next         = g_reg;
        cls_next       = cls_reg;
        big_next       = big_reg;
        move_next      = move_reg;
        old_cls_next   = old_cls_reg;
        old_bytes_next = old_bytes_reg;
        st_next        = st_reg;
        ok_next        = ok_reg;
        where_next     = where_reg;
        copy_next      = copy_reg;

        heads_raddr = cls_reg;
        heads_we    = 1'b0;
        heads_waddr = cls_reg;
        heads_wdata = g_reg;
        meta_raddr  = g_reg;
        meta_waddr  = g_reg;
        stat_we     = 1'b0;
        stat_wdata  = BS_LIVE;
        class_we    = 1'b0;
        link_we     = 1'b0;
        link_wdata  = heads_rd_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // one status entry per cycle; heads ride along on the low bits
                stat_we      = 1'b1;
                stat_wdata   = BS_NONE;
                meta_waddr   = clr_cnt_reg;
                heads_we     = (clr_cnt_reg < 16'(NUM_CLASSES));
                heads_waddr  = clr_cnt_reg[CLASS_W-1:0];
                heads_wdata  = '0;
                clr_cnt_next = clr_cnt_reg + 16'd1;
                if (clr_cnt_reg == {GRAN_W{1'b1}})
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    bytes_next = req.request_bytes;
                    has_next   = req.has_block;
                    g_next     = req.block_granule;
                    cls_next   = req_info.cls;
                    big_next   = req_info.too_large;
                    move_next  = 1'b0;
                    st_next    = STAT_OK;
                    ok_next    = 1'b0;
                    where_next = '0;
                    copy_next  = '0;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // heads read at cls_reg and metadata read at g_reg issue here
                if (alloc_path)
                begin
                    if (big_reg)
                    begin
                        st_next    = STAT_LARGE;
                        state_next = S_FINISH;
                    end
                    else
                        state_next = S_A_HEAD;
                end
                else if (free_path)
                    state_next = has_reg ? S_F_CHK : S_FINISH;
                else if (op_reg == OP_REALLOC)
                    state_next = S_R_CHK;
                else
                    state_next = S_FINISH;
            end

            S_A_HEAD:
            begin
                if (heads_rd_reg != '0)
                begin
                    // pop: check the head block and fetch its link
                    where_next = heads_rd_reg;
                    meta_raddr = heads_rd_reg;
                    state_next = S_A_POP;
                end
                else if (end_top > {1'b0, limit_eff})
                begin
                    st_next    = STAT_SPACE;
                    state_next = S_FINISH;
                end
                else
                begin
                    meta_waddr  = bump_reg[GRAN_W-1:0] + 16'd1;
                    stat_we     = 1'b1;
                    class_we    = 1'b1;
                    bump_next   = end_top[TOP_W-1:0];
                    where_next  = bump_reg[GRAN_W-1:0] + 16'd1;
                    ok_next     = 1'b1;
                    heads_raddr = old_cls_reg;
                    state_next  = move_reg ? S_P_WR : S_FINISH;
                end
            end

            S_A_POP:
            begin
                if (stat_rd_reg != BS_FREED)
                begin
                    st_next    = STAT_CORRUPT;
                    state_next = S_FINISH;
                end
                else
                begin
                    heads_we    = 1'b1;
                    heads_waddr = cls_reg;
                    heads_wdata = link_rd_reg;
                    meta_waddr  = where_reg;
                    stat_we     = 1'b1;
                    class_we    = 1'b1;
                    ok_next     = 1'b1;
                    // old block's class differs from the new one, so no clash
                    heads_raddr = old_cls_reg;
                    state_next  = move_reg ? S_P_WR : S_FINISH;
                end
            end

            S_F_CHK:
            begin
                if (stat_rd_reg != BS_LIVE)
                begin
                    st_next    = STAT_NOTLIVE;
                    state_next = S_FINISH;
                end
                else
                begin
                    old_cls_next = class_rd_reg;
                    heads_raddr  = class_rd_reg;
                    state_next   = S_P_WR;
                end
            end

            S_R_CHK:
            begin
                if (stat_rd_reg != BS_LIVE)
                begin
                    st_next    = STAT_NOTLIVE;
                    state_next = S_FINISH;
                end
                else if (bytes_reg <= {4'd0, rd_old_bytes})
                begin
                    // still fits: keep the block in place
                    where_next = g_reg;
                    ok_next    = 1'b1;
                    state_next = S_FINISH;
                end
                else if (big_reg)
                begin
                    st_next    = STAT_LARGE;
                    state_next = S_FINISH;
                end
                else
                begin
                    move_next      = 1'b1;
                    old_cls_next   = class_rd_reg;
                    old_bytes_next = rd_old_bytes;
                    state_next     = S_A_HEAD;
                end
            end

            S_P_WR:
            begin
                // push g_reg onto its class list
                link_we     = 1'b1;
                link_wdata  = heads_rd_reg;
                meta_waddr  = g_reg;
                stat_we     = 1'b1;
                stat_wdata  = BS_FREED;
                heads_we    = 1'b1;
                heads_waddr = old_cls_reg;
                heads_wdata = g_reg;
                if (move_reg)
                    copy_next = old_bytes_reg[18:0];
                state_next  = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status         = st_reg;
                    rsp_next.result_valid   = ok_reg;
                    rsp_next.result_granule = ok_reg ? where_reg : '0;
                    rsp_next.copy_bytes     = copy_reg;
                    rsp_next.used_granules  = bump_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // bump pointer only moves forward
    a_bump_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid || !req_valid |=> bump_reg >= $past(bump_reg))
        else $error("bump pointer moved backward");

    // bump pointer stays inside the region
    a_bump_in_region: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg <= 17'(REGION_GRANULES) && bump_reg != '0)
        else $error("bump pointer outside region");

    // a returned block is nonnull and comes with an ok status
    a_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_valid |-> rsp.status == STAT_OK && rsp.result_granule != '0)
        else $error("returned block with bad status or null granule");
`endif

endmodule

`default_nettype wire

// ----- dv/size_class_free_list_allocator_tb.sv -----
// Self-checking testbench for size_class_free_list_allocator: directed and random
// allocate/free/reallocate traffic, checked against an in-bench allocator predictor.
// Depends on scfla_pkg (request/response structs, operation and status codes).
`default_nettype none

module size_class_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scfla_pkg::*;

    // the one operation code the block decodes as "do nothing"
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int GRAN_BYTES    = 16;
    localparam int PAGE_GRANULES = 256;
    localparam int MAX_BYTES     = LARGE_CLASSES * 4096;
    // margin after draining so the block settles back to idle
    localparam int SETTLE_CYCLES = 16;
    // receiver hold-off long enough that the block backs up onto its input
    localparam int HOLD_CYCLES   = 400;
    // covers the clearing pass plus ~1600 requests at heavy idling
    localparam int CYCLE_LIMIT   = 1000000;

    // ------------------------------------------------------------------
    // Allocator predictor and response scoreboard. Holds its own copy of
    // the list heads, per-granule metadata, bump pointer and reserve limit.
    // ------------------------------------------------------------------
    class alloc_scoreboard;
        logic [15:0] list_head [NUM_CLASSES];
        logic [1:0]  gran_state [REGION_GRANULES];
        logic [8:0]  gran_class [REGION_GRANULES];
        logic [15:0] gran_link [REGION_GRANULES];
        int unsigned top_granule;
        int unsigned reserve;
        rsp_t        pending_rsp [$];
        int unsigned live_blocks [$];
        int unsigned last_where;
        int          mismatches;
        int          accepted;
        int          checked;
        int          pops;
        int          moves;
        int          status_seen [8];

        function new();
            foreach (list_head[i])
                list_head[i] = '0;
            foreach (gran_state[i])
            begin
                gran_state[i] = BS_NONE;
                gran_class[i] = '0;
                gran_link[i]  = '0;
            end
            foreach (status_seen[i])
                status_seen[i] = 0;
            top_granule = 1;
            reserve     = 65536;
            last_where  = 0;
            mismatches  = 0;
            accepted    = 0;
            checked     = 0;
            pops        = 0;
            moves       = 0;
        endfunction

        // returns 1 when the size is beyond the largest class
        function bit size_to_class(input int unsigned bytes, output int unsigned cls);
            int unsigned pages;
            cls = 0;
            if (bytes <= SMALL_CLASSES * 16)
            begin
                cls = (bytes + 15) >> 4;
                return 1'b0;
            end
            pages = (bytes + 4095) >> 12;
            if (pages > LARGE_CLASSES)
                return 1'b1;
            cls = SMALL_CLASSES + pages;
            return 1'b0;
        endfunction

        function int unsigned class_capacity(input int unsigned cls);
            if (cls <= SMALL_CLASSES)
                return cls;
            return (cls - SMALL_CLASSES) * PAGE_GRANULES;
        endfunction

        function int unsigned block_bytes(input int unsigned g);
            return class_capacity(gran_class[g]) * GRAN_BYTES;
        endfunction

        function bit block_is_live(input logic [15:0] g);
            return gran_state[g] == BS_LIVE;
        endfunction

        // pop the class list if possible, otherwise bump past header + payload
        function logic [2:0] take_block(input int unsigned bytes, output int unsigned where);
            int unsigned cls;
            int unsigned head;
            int unsigned lim;
            int unsigned fin;
            where = 0;
            if (bytes == 0)
                bytes = 1;
            if (size_to_class(bytes, cls))
                return STAT_LARGE;
            head = list_head[cls];
            if (head != 0)
            begin
                if (gran_state[head] != BS_FREED)
                    return STAT_CORRUPT;
                list_head[cls] = gran_link[head];
                pops++;
            end
            else
            begin
                lim = (reserve > REGION_GRANULES) ? REGION_GRANULES : reserve;
                fin = top_granule + 1 + class_capacity(cls);
                if (fin > lim)
                    return STAT_SPACE;
                head        = top_granule + 1;
                top_granule = fin;
            end
            gran_state[head] = BS_LIVE;
            gran_class[head] = 9'(cls);
            live_blocks.push_back(head);
            where = head;
            return STAT_OK;
        endfunction

        function void release_block(input int unsigned g);
            int unsigned cls;
            cls = gran_class[g];
            if (cls >= NUM_CLASSES)
                cls = 0;
            gran_link[g]   = list_head[cls];
            list_head[cls] = 16'(g);
            gran_state[g]  = BS_FREED;
            foreach (live_blocks[i])
                if (live_blocks[i] == g)
                begin
                    live_blocks.delete(i);
                    break;
                end
        endfunction

        // called at the edge a request is accepted
        function void note_request(input req_t r);
            rsp_t        want;
            logic [2:0]  st;
            int unsigned where;
            int unsigned old_bytes;
            int unsigned copy;
            bit          ok;
            st    = STAT_OK;
            where = 0;
            copy  = 0;
            ok    = 1'b0;
            accepted++;
            if (r.operation == OP_ALLOC || (r.operation == OP_REALLOC && !r.has_block))
            begin
                st = take_block(r.request_bytes, where);
                ok = (st == STAT_OK);
            end
            else if (r.operation == OP_FREE ||
                     (r.operation == OP_REALLOC && r.request_bytes == 0))
            begin
                // a null pointer frees nothing
                if (r.has_block)
                begin
                    if (block_is_live(r.block_granule))
                        release_block(r.block_granule);
                    else
                        st = STAT_NOTLIVE;
                end
            end
            else if (r.operation == OP_REALLOC)
            begin
                if (!block_is_live(r.block_granule))
                    st = STAT_NOTLIVE;
                else
                begin
                    old_bytes = block_bytes(r.block_granule);
                    if (r.request_bytes <= old_bytes)
                    begin
                        where = r.block_granule;
                        ok    = 1'b1;
                    end
                    else
                    begin
                        // on a failed move the old block stays live
                        st = take_block(r.request_bytes, where);
                        if (st == STAT_OK)
                        begin
                            release_block(r.block_granule);
                            ok   = 1'b1;
                            copy = old_bytes;
                            moves++;
                        end
                    end
                end
            end
            if (!ok)
                where = 0;
            last_where          = where;
            want.status         = st;
            want.result_valid   = ok;
            want.result_granule = 16'(where);
            want.copy_bytes     = 19'(copy);
            want.used_granules  = 17'(top_granule);
            status_seen[st]++;
            pending_rsp.push_back(want);
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] MISMATCH response %0d: %s", $realtime, checked, msg);
        endtask

        task check_response(input rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("response with no request outstanding");
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.result_valid !== want.result_valid)
                report_mismatch($sformatf("result_valid %0d, expected %0d",
                                          got.result_valid, want.result_valid));
            if (got.result_granule !== want.result_granule)
                report_mismatch($sformatf("result_granule %0d, expected %0d",
                                          got.result_granule, want.result_granule));
            if (got.copy_bytes !== want.copy_bytes)
                report_mismatch($sformatf("copy_bytes %0d, expected %0d",
                                          got.copy_bytes, want.copy_bytes));
            if (got.used_granules !== want.used_granules)
                report_mismatch($sformatf("used_granules %0d, expected %0d",
                                          got.used_granules, want.used_granules));
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // Signals. Every block input has a known value from time zero.
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        cfg_write = 1'b0;
    logic [16:0] cfg_data  = '0;

    alloc_scoreboard sb;
    int          recv_stall_pct = 0;
    int          hold_trigger   = 0;
    int          cycle_count    = 0;

    // a few favorite small classes keep the free lists busy, so most allocates
    // are pops rather than bumps and the region lasts through the run
    int unsigned favorite_class [8] = '{1, 2, 3, 4, 8, 16, 64, 256};

    size_class_free_list_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Response side: checks at the accepting edge, then decides the next
    // ready. A hold-off, once triggered, is counted out here cycle by cycle.
    always @(posedge clk)
    begin : response_sink
        int hold_left;
        int hold_taken;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_trigger != hold_taken)
            begin
                hold_taken = hold_trigger;
                hold_left  = HOLD_CYCLES;
                rsp_ready  <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run if the traffic never drains.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d requests still outstanding",
                 cycle_count, sb.pending_rsp.size());
        $display("size_class_free_list_allocator verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Offer one request after a random gap; returns at the accepting edge,
    // leaving valid high so back-to-back requests need no extra assignment.
    task automatic send_request(input req_t r, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // Sender pauses until every response is back, then lets the block settle.
    task automatic drain_and_settle();
        req_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Called with no request outstanding; the predictor picks it up at that edge.
    task automatic set_reserve_limit(input logic [16:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        sb.reserve = value;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic req_t make_req(input logic [1:0] op, input int unsigned bytes,
                                      input bit has, input int unsigned g);
        req_t r;
        r.operation     = op;
        r.request_bytes = 24'(bytes);
        r.has_block     = has;
        r.block_granule = 16'(g);
        return r;
    endfunction

    // Size mix: mostly favorite small classes, some arbitrary small sizes,
    // a few page-sized, rarely the biggest classes or oversize.
    function automatic int unsigned pick_bytes();
        int          k;
        int unsigned cls;
        k = $urandom_range(99);
        if (k < 60)
        begin
            cls = favorite_class[$urandom_range(7)];
            return $urandom_range(cls * 16, cls * 16 - 15);
        end
        else if (k < 63)
            return 0;
        else if (k < 90)
            return $urandom_range(SMALL_CLASSES * 16, 1);
        else if (k < 96)
            return $urandom_range(4 * 4096, SMALL_CLASSES * 16 + 1);
        else if (k < 98)
            return $urandom_range(MAX_BYTES, SMALL_CLASSES * 16 + 1);
        else
            return $urandom_range(24'hFFFFFF, MAX_BYTES + 1);
    endfunction

    // Mostly well-formed traffic on live blocks; a tenth is noise.
    function automatic req_t make_request();
        req_t        r;
        int          pick;
        int          sub;
        int unsigned g;
        int unsigned cap;
        r.operation     = OP_ALLOC;
        r.request_bytes = 24'($urandom);
        r.has_block     = 1'b1;
        r.block_granule = 16'($urandom);
        pick = $urandom_range(99);
        if (sb.live_blocks.size() < 4)
            pick = $urandom_range(34);
        else if (sb.live_blocks.size() > 48)
            pick = $urandom_range(89, 35);
        if (sb.live_blocks.size() != 0)
            g = sb.live_blocks[$urandom_range(sb.live_blocks.size() - 1)];
        else
            g = 0;
        if (pick < 35)
        begin
            // plain allocate, or reallocate of a null pointer
            r.request_bytes = 24'(pick_bytes());
            if ($urandom_range(4) == 0)
            begin
                r.operation = OP_REALLOC;
                r.has_block = 1'b0;
            end
        end
        else if (pick < 65 && g != 0)
        begin
            r.operation     = OP_FREE;
            r.block_granule = 16'(g);
        end
        else if (pick < 90 && g != 0)
        begin
            r.operation     = OP_REALLOC;
            r.block_granule = 16'(g);
            cap = sb.block_bytes(g);
            sub = $urandom_range(19);
            if (sub < 2)
                r.request_bytes = '0;
            else if (sub < 11)
                r.request_bytes = 24'($urandom_range(cap, 1));
            else
                r.request_bytes = 24'(pick_bytes());
        end
        else
        begin
            sub = $urandom_range(4);
            case (sub)
                0: r.operation = OP_UNUSED;
                1:
                begin
                    r.operation = OP_FREE;
                    r.has_block = 1'b0;
                end
                2: r.operation = OP_FREE;      // random granule, almost never live
                3: r.operation = OP_REALLOC;
                default: r.request_bytes = 24'($urandom_range(24'hFFFFFF, MAX_BYTES + 1));
            endcase
        end
        return r;
    endfunction

    // Random phase; do-nothing requests do not count toward the total.
    task automatic run_phase(input int count, input int sender_idle, input int recv_stall);
        int   sent;
        req_t r;
        recv_stall_pct = recv_stall;
        sent = 0;
        while (sent < count)
        begin
            r = make_request();
            send_request(r, sender_idle);
            if (r.operation != OP_UNUSED)
                sent++;
        end
    endtask

    // Edge cases: zero size, class boundaries, the largest class and oversize,
    // null frees, double free, pops, reallocate in place / moved / to zero,
    // failed move, and the unused operation code.
    task automatic run_directed();
        int unsigned a;
        int unsigned b;
        int unsigned d;
        int unsigned f;
        send_request(make_req(OP_ALLOC, 0, 1'b0, 0), 0);
        a = sb.last_where;
        send_request(make_req(OP_ALLOC, 16, 1'b0, 0), 0);
        b = sb.last_where;
        send_request(make_req(OP_ALLOC, 17, 1'b0, 16'hFFFF), 0);
        send_request(make_req(OP_ALLOC, SMALL_CLASSES * 16, 1'b0, 0), 0);
        send_request(make_req(OP_ALLOC, SMALL_CLASSES * 16 + 1, 1'b0, 0), 0);
        d = sb.last_where;
        send_request(make_req(OP_ALLOC, MAX_BYTES, 1'b0, 0), 0);
        send_request(make_req(OP_ALLOC, MAX_BYTES + 1, 1'b0, 0), 0);
        send_request(make_req(OP_ALLOC, 24'hFFFFFF, 1'b1, 16'hFFFF), 0);
        send_request(make_req(OP_FREE, 24'hFFFFFF, 1'b0, 16'h5A5A), 0);
        send_request(make_req(OP_FREE, 0, 1'b1, a), 0);
        send_request(make_req(OP_FREE, 0, 1'b1, a), 0);       // double free
        send_request(make_req(OP_FREE, 0, 1'b1, 16'hFFFF), 0);
        send_request(make_req(OP_FREE, 0, 1'b1, 0), 0);
        send_request(make_req(OP_ALLOC, 5, 1'b0, 0), 0);      // pops a back off class 1
        send_request(make_req(OP_REALLOC, 100, 1'b0, 0), 0);
        send_request(make_req(OP_REALLOC, 10, 1'b1, b), 0);    // fits, stays put
        send_request(make_req(OP_REALLOC, 16, 1'b1, b), 0);
        send_request(make_req(OP_REALLOC, 4000, 1'b1, b), 0);  // moves, copies 16
        f = sb.last_where;
        send_request(make_req(OP_REALLOC, 0, 1'b1, f), 0);     // frees, null result
        send_request(make_req(OP_REALLOC, 64, 1'b1, f), 0);    // no longer live
        send_request(make_req(OP_REALLOC, 24'hFFFFFF, 1'b1, d), 0);
        send_request(make_req(OP_UNUSED, 24'hFFFFFF, 1'b1, 16'hFFFF), 0);
        send_request(make_req(OP_REALLOC, 0, 1'b0, 0), 0);     // null, size zero
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_reserve_limit(17'd65536);

        // directed checks, then free-running traffic with no idling
        run_directed();
        drain_and_settle();
        run_phase(400, 0, 0);
        drain_and_settle();

        // all-ones limit clamps to the region size; sparse sender
        set_reserve_limit(17'h1FFFF);
        run_phase(250, 79, 0);
        drain_and_settle();

        // little headroom above the bump pointer: out-of-space and failed moves
        set_reserve_limit(17'(sb.top_granule + 300));
        run_phase(250, 0, 79);
        drain_and_settle();

        // smallest limit: every bump fails, so only list pops and in-place reallocates return a block
        set_reserve_limit(17'd1);
        run_phase(150, 32, 32);
        drain_and_settle();

        // receiver holds off while the sender keeps offering, so the block
        // backs up and drops req_ready
        set_reserve_limit(17'd65536);
        hold_trigger++;
        run_phase(100, 0, 0);
        drain_and_settle();

        run_phase(400, 32, 32);
        drain_and_settle();

        $display("Covered %0d requests, %0d checked: ok %0d, space %0d, large %0d, not live %0d",
                 sb.accepted, sb.checked, sb.status_seen[STAT_OK], sb.status_seen[STAT_SPACE],
                 sb.status_seen[STAT_LARGE], sb.status_seen[STAT_NOTLIVE]);
        $display("Free-list pops %0d, moved reallocates %0d, final bump %0d, %0d mismatches",
                 sb.pops, sb.moves, sb.top_granule, sb.mismatches);
        if (sb.mismatches == 0)
            $display("size_class_free_list_allocator verification clean");
        else
            $display("size_class_free_list_allocator verification failed");
        $finish;
    end

endmodule

`default_nettype wire
